[rtl/huffman_decode_tree_builder_assert.svh]
// Assertion macros for the Huffman decode tree builder.
// Uses the including module's clk and rst; no other dependencies.
`ifndef HUFFMAN_DECODE_TREE_BUILDER_ASSERT_SVH
`define HUFFMAN_DECODE_TREE_BUILDER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HDT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hdt: same-cycle check failed");
// next-cycle implication
`define HDT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hdt: next-cycle check failed");
`else
`define HDT_ASSERT_NOW(label, ante, cons)
`define HDT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/hdt_pkg.sv]
// Shared types and constants for the Huffman decode tree builder.
// No dependencies.
`default_nettype none

package hdt_pkg;

  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int SYM_IN_W     = 9;
  localparam int COUNT_W      = 10;
  localparam int MAX_CODE_LEN = 32;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_LEAF_IN_PATH = 2'd1,
    ST_FULL         = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALIGN,
    S_WALK,
    S_ALLOC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic advance;
  } shift_ctl_t;

endpackage

`default_nettype wire

[rtl/hdt_bit_shifter.sv]
// Code bit shifter: loads a right-aligned codeword, shifts it up until the
// first code bit sits at the MSB, then hands out one bit per advance.
// Depends on hdt_pkg.
`default_nettype none

module hdt_bit_shifter (
  input  logic                       clk,
  input  logic                       rst,
  input  hdt_pkg::shift_ctl_t        ctl,
  input  logic [hdt_pkg::CODE_W-1:0] code_in,
  input  logic [hdt_pkg::LEN_W-1:0]  len_in,
  output logic                       bit_out,
  output logic                       aligned
);
  import hdt_pkg::*;

  logic [CODE_W-1:0] sr;
  logic [LEN_W-1:0]  skip;  // alignment shifts still to go

  always_ff @(posedge clk) begin
    if (rst) begin
      skip <= '0;
    end else if (ctl.load) begin
      skip <= LEN_W'(CODE_W) - len_in;
    end else if (skip != '0) begin
      skip <= skip - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sr <= code_in;
    end else if (skip != '0 || ctl.advance) begin
      sr <= {sr[CODE_W-2:0], 1'b0};
    end
  end

  assign bit_out = sr[CODE_W-1];
  assign aligned = (skip == '0);

endmodule

`default_nettype wire

[rtl/hdt_node_store.sv]
// Node store: root entry in flip-flops, all other entries in a memory with
// one write and one registered read port. Each entry holds two child slots.
// Depends on hdt_pkg.
`default_nettype none

module hdt_node_store #(
  parameter int MAX_NODES = 512,
  parameter int SLOT_W    = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear_root,
  input  logic [$clog2(MAX_NODES)-1:0] rd_addr,
  output logic [2*SLOT_W-1:0]          rd_entry,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_NODES)-1:0] wr_addr,
  input  logic [2*SLOT_W-1:0]          wr_data
);
  import hdt_pkg::*;

  logic [2*SLOT_W-1:0] mem [MAX_NODES];
  logic [2*SLOT_W-1:0] mem_q;
  logic [2*SLOT_W-1:0] root;
  logic                rd_root;

  // entries above the root are written on allocation before any read
  always_ff @(posedge clk) begin
    if (wr_en && wr_addr != '0) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q   <= mem[rd_addr];
    rd_root <= (rd_addr == '0);
  end

  always_ff @(posedge clk) begin
    if (rst || clear_root) begin
      root <= '0;
    end else if (wr_en && wr_addr == '0) begin
      root <= wr_data;
    end
  end

  assign rd_entry = rd_root ? root : mem_q;

endmodule

`default_nettype wire

[rtl/huffman_decode_tree_builder.sv]
// Huffman decode tree builder, top level: control sequencer, counters and
// result register. Depends on hdt_pkg, hdt_bit_shifter, hdt_node_store and
// huffman_decode_tree_builder_assert.svh.
// Usage:
//   Input channel (in_valid/in_ready) carries one codeword insert per
//   transfer: start_new, codeword, code_length, symbol_index. Output channel
//   (out_valid/out_ready) returns exactly one result per insert: status,
//   node_count, tree_complete, longest_length.
//   The code is shifted up one bit a cycle until its leading bit tops the
//   32-bit shifter (32 - length shifts, then the root is read), then
//   walked one bit a cycle through the node store, then new nodes are written
//   one per cycle, ending with the leaf. An insert that writes a leaf takes
//   the same time from input transfer to result valid, whatever its length;
//   one that stops on a leaf or an internal node is done sooner, a zero
//   length insert soonest. The next insert is taken the cycle after its
//   result loads, and no insert is taken while one is in progress.
//   The result sits in an output register: the next insert is taken while
//   it waits; if the receiver stalls, the following result waits in the
//   sequencer and no further input is taken. Reset: lone root, node_count 1,
//   longest_length 0, no clearing pass (unwritten entries are never read).
`default_nettype none
`include "huffman_decode_tree_builder_assert.svh"

module huffman_decode_tree_builder #(
  parameter int MAX_NODES   = 512,
  parameter int MAX_SYMBOLS = 512
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         start_new,
  input  logic [hdt_pkg::CODE_W-1:0]   codeword,
  input  logic [hdt_pkg::LEN_W-1:0]    code_length,
  input  logic [hdt_pkg::SYM_IN_W-1:0] symbol_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic [hdt_pkg::COUNT_W-1:0]  node_count,
  output logic                         tree_complete,
  output logic [hdt_pkg::LEN_W-1:0]    longest_length
);
  import hdt_pkg::*;

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int SYM_W  = $clog2(MAX_SYMBOLS);
  localparam int VAL_W  = (NODE_W > SYM_W) ? NODE_W : SYM_W;
  localparam int SLOT_W = VAL_W + 1;          // leaf flag + value; all zero = unset
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int OPEN_W = $clog2(MAX_NODES + 2);
  localparam int SUM_W  = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

  state_t state, state_next;

  // control state
  logic [CNT_W-1:0]  nodes_used;
  logic [OPEN_W-1:0] open_slots;
  logic [LEN_W-1:0]  max_len;

  // per-insert working registers
  logic [NODE_W-1:0]   cur;
  logic [LEN_W-1:0]    rem;        // code bits left, counting the current one
  logic [2*SLOT_W-1:0] entry_q;    // entry of cur, merged on the next write
  logic [VAL_W-1:0]    sym_q;
  status_t             status_q;

  shift_ctl_t          sh_ctl;
  logic                sh_bit;
  logic                sh_aligned;
  logic                clear_root;
  logic [NODE_W-1:0]   rd_addr;
  logic [2*SLOT_W-1:0] rd_entry;
  logic                wr_en;
  logic [2*SLOT_W-1:0] wr_data;
  logic                out_load;

  logic [LEN_W-1:0]  len_sat;
  logic [VAL_W-1:0]  sym_sat;
  logic [SLOT_W-1:0] walk_slot;
  logic              slot_unset;
  logic              slot_leaf;
  logic [NODE_W-1:0] slot_node;
  logic              store_full;
  logic [SLOT_W-1:0] new_slot;
  logic              accept;

  assign accept = in_valid && in_ready;

  // input clamps
  assign len_sat = (code_length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : code_length;
  assign sym_sat = ({23'd0, symbol_index} >= 32'(MAX_SYMBOLS)) ?
                   VAL_W'(MAX_SYMBOLS - 1) : VAL_W'(symbol_index);

  // slot picked by the current code bit
  assign walk_slot  = sh_bit ? rd_entry[2*SLOT_W-1:SLOT_W] : rd_entry[SLOT_W-1:0];
  assign slot_unset = (walk_slot == '0);
  assign slot_leaf  = walk_slot[SLOT_W-1];
  assign slot_node  = walk_slot[NODE_W-1:0];

  // nodes still needed: one per remaining bit after the current one
  assign store_full = (SUM_W'(nodes_used) + SUM_W'(rem) - SUM_W'(1)) > SUM_W'(MAX_NODES);

  // allocation write: leaf on the last bit, else link to a fresh node
  assign new_slot = (rem == LEN_W'(1)) ? {1'b1, sym_q} : {1'b0, VAL_W'(nodes_used)};
  assign wr_data  = sh_bit ? {new_slot, entry_q[SLOT_W-1:0]}
                           : {entry_q[2*SLOT_W-1:SLOT_W], new_slot};
  assign wr_en    = (state == S_ALLOC);

  hdt_bit_shifter u_shifter (
    .clk     (clk),
    .rst     (rst),
    .ctl     (sh_ctl),
    .code_in (codeword),
    .len_in  (len_sat),
    .bit_out (sh_bit),
    .aligned (sh_aligned)
  );

  hdt_node_store #(
    .MAX_NODES (MAX_NODES),
    .SLOT_W    (SLOT_W)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .clear_root (clear_root),
    .rd_addr    (rd_addr),
    .rd_entry   (rd_entry),
    .wr_en      (wr_en),
    .wr_addr    (cur),
    .wr_data    (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    sh_ctl.load    = 1'b0;
    sh_ctl.advance = 1'b0;
    clear_root     = 1'b0;
    rd_addr        = '0;
    in_ready       = 1'b0;
    out_load       = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          sh_ctl.load = 1'b1;
          clear_root  = start_new;
          state_next  = (len_sat == '0) ? S_DONE : S_ALIGN;
        end
      end
      S_ALIGN: begin
        // read address stays on the root
        if (sh_aligned) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        priority if (slot_unset) begin
          state_next = store_full ? S_DONE : S_ALLOC;
        end else if (slot_leaf) begin
          state_next = S_DONE;
        end else begin
          sh_ctl.advance = 1'b1;
          rd_addr        = slot_node;
          if (rem == LEN_W'(1)) begin
            state_next = S_DONE;
          end
        end
      end
      S_ALLOC: begin
        if (rem == LEN_W'(1)) begin
          state_next = S_DONE;
        end else begin
          sh_ctl.advance = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // tree counters and longest length
  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_used <= CNT_W'(1);
      open_slots <= OPEN_W'(2);
      max_len    <= '0;
    end else begin
      if (accept) begin
        if (start_new) begin
          nodes_used <= CNT_W'(1);
          open_slots <= OPEN_W'(2);
        end
        if (len_sat > max_len) begin
          max_len <= len_sat;
        end
      end else if (state == S_ALLOC) begin
        if (rem == LEN_W'(1)) begin
          open_slots <= open_slots - OPEN_W'(1);
        end else begin
          nodes_used <= nodes_used + CNT_W'(1);
          open_slots <= open_slots + OPEN_W'(1);
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      rem      <= len_sat;
      cur      <= '0;
      sym_q    <= sym_sat;
      status_q <= ST_OK;
    end else if (state == S_WALK) begin
      priority if (slot_unset) begin
        entry_q <= rd_entry;
        if (store_full) begin
          status_q <= ST_FULL;
        end
      end else if (slot_leaf) begin
        status_q <= ST_LEAF_IN_PATH;
      end else begin
        cur <= slot_node;
        rem <= rem - LEN_W'(1);
      end
    end else if (state == S_ALLOC && rem != LEN_W'(1)) begin
      cur     <= NODE_W'(nodes_used);
      entry_q <= '0;
      rem     <= rem - LEN_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status         <= status_q;
      node_count     <= COUNT_W'(nodes_used);
      tree_complete  <= (open_slots == '0);
      longest_length <= max_len;
    end
  end

  `HDT_ASSERT_NOW(a_nodes_bound, 1'b1, nodes_used <= CNT_W'(MAX_NODES))
  `HDT_ASSERT_NOW(a_walk_aligned, state == S_WALK || state == S_ALLOC, sh_aligned)
  `HDT_ASSERT_NOW(a_rem_live, state == S_WALK || state == S_ALLOC, rem != '0)
  `HDT_ASSERT_NEXT(a_leaf_closes_slot, state == S_ALLOC && rem == LEN_W'(1),
                   open_slots + OPEN_W'(1) == $past(open_slots))

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for huffman_decode_tree_builder: streams codeword inserts, predicts
// each result with a behavioral tree model and compares every output transfer.
// Depends on hdt_pkg and the RTL of the block; nothing else.
module tb;
  import hdt_pkg::*;

  localparam int NODE_LIMIT   = 512;
  localparam int SYM_LIMIT    = 512;
  localparam int ITEM_TARGET  = 1650;
  localparam int DRAIN_CYCLES = 80;   // idle wait after the last result, for a stray extra one
  localparam int MAX_REPORTS  = 30;

  // one insert as it crosses the input channel
  typedef struct packed {
    logic                start_new;
    logic [CODE_W-1:0]   codeword;
    logic [LEN_W-1:0]    code_length;
    logic [SYM_IN_W-1:0] symbol_index;
  } insert_t;

  // one result as it crosses the output channel
  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] node_count;
    logic               tree_complete;
    logic [LEN_W-1:0]   longest_length;
  } tree_result_t;

  // child slot of a tree node: unset, pointer to an internal node, or a symbol leaf
  typedef enum logic [1:0] {SLOT_OPEN, SLOT_BRANCH, SLOT_LEAF} slot_kind_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic                start_new    = 1'b0;
  logic [CODE_W-1:0]   codeword     = '0;
  logic [LEN_W-1:0]    code_length  = '0;
  logic [SYM_IN_W-1:0] symbol_index = '0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [1:0]          status;
  logic [COUNT_W-1:0]  node_count;
  logic                tree_complete;
  logic [LEN_W-1:0]    longest_length;

  always #5 clk = ~clk;

  huffman_decode_tree_builder #(
    .MAX_NODES  (NODE_LIMIT),
    .MAX_SYMBOLS(SYM_LIMIT)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .start_new     (start_new),
    .codeword      (codeword),
    .code_length   (code_length),
    .symbol_index  (symbol_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .node_count    (node_count),
    .tree_complete (tree_complete),
    .longest_length(longest_length)
  );

  // ---------------------------------------------------------------------------
  // Tree model: own copy of the node store and counters
  // ---------------------------------------------------------------------------
  slot_kind_t          slot_kind [NODE_LIMIT][2];
  logic [SYM_IN_W-1:0] slot_ref  [NODE_LIMIT][2];  // node index or symbol
  int                  nodes_used;
  int                  open_slots;
  int                  longest_seen;

  function automatic void clear_tree();
    slot_kind[0][0] = SLOT_OPEN;
    slot_kind[0][1] = SLOT_OPEN;
    nodes_used      = 1;
    open_slots      = 2;
  endfunction

  // Applies one insert to the model and returns the result it should produce.
  function automatic tree_result_t insert_code(insert_t it);
    int                  len;
    int                  rem;
    int                  cur;
    int                  fresh;
    logic                b;
    logic [SYM_IN_W-1:0] sym;
    bit                  hit_open;
    bit                  hit_leaf;
    tree_result_t        r;

    if (it.start_new) clear_tree();
    len = int'(it.code_length);
    if (len > MAX_CODE_LEN) len = MAX_CODE_LEN;
    if (len > longest_seen) longest_seen = len;
    sym = (int'(it.symbol_index) >= SYM_LIMIT) ? SYM_IN_W'(SYM_LIMIT - 1) : it.symbol_index;

    // follow existing branches, MSB of the code first
    rem      = len;
    cur      = 0;
    b        = 1'b0;
    hit_open = 1'b0;
    hit_leaf = 1'b0;
    while (rem > 0 && !hit_open && !hit_leaf) begin
      rem--;
      b = it.codeword[rem];
      case (slot_kind[cur][b])
        SLOT_OPEN: hit_open = 1'b1;
        SLOT_LEAF: hit_leaf = 1'b1;
        default:   cur = int'(slot_ref[cur][b]);
      endcase
    end

    r.status = ST_OK;
    if (hit_leaf) begin
      r.status = ST_LEAF_IN_PATH;
    end else if (hit_open) begin
      // rem more bits: rem new internal nodes, then the leaf; all or nothing
      if (nodes_used + rem > NODE_LIMIT) begin
        r.status = ST_FULL;
      end else begin
        while (rem > 0) begin
          fresh              = nodes_used;
          slot_kind[cur][b]  = SLOT_BRANCH;
          slot_ref[cur][b]   = SYM_IN_W'(fresh);
          slot_kind[fresh][0] = SLOT_OPEN;
          slot_kind[fresh][1] = SLOT_OPEN;
          nodes_used++;
          open_slots++;
          cur = fresh;
          rem--;
          b = it.codeword[rem];
        end
        slot_kind[cur][b] = SLOT_LEAF;
        slot_ref[cur][b]  = sym;
        open_slots--;
      end
    end
    // ending on an internal node falls through here: ok, tree untouched

    r.node_count     = COUNT_W'(nodes_used);
    r.tree_complete  = (open_slots == 0);
    r.longest_length = LEN_W'(longest_seen);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard state
  // ---------------------------------------------------------------------------
  insert_t      pending_inserts[$];   // filled up front, drained by the sender
  tree_result_t expected_results[$];  // one per accepted insert, oldest first
  int           errors        = 0;
  int           results_seen  = 0;
  int           inserts_taken = 0;
  int           status_tally[3] = '{0, 0, 0};
  int           complete_tally = 0;
  int           peak_count     = 0;

  task automatic flag_mismatch(string what, longint got, longint want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("MISMATCH @%0t result #%0d %s: got %0d, want %0d",
               $time, results_seen, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of back-to-back transfers separated by random gaps.
  // in_taken is set by the monitor on the accepting edge and consumed here.
  // ---------------------------------------------------------------------------
  bit in_taken   = 1'b0;
  int gap_left   = 0;
  int burst_left = 1;

  always @(negedge clk) begin : sender
    logic    next_valid;
    insert_t it;
    next_valid = in_valid;
    if (in_taken) begin
      next_valid = 1'b0;
      in_taken   = 1'b0;
    end
    if (!rst && !next_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_inserts.size() > 0) begin
        it = pending_inserts.pop_front();
        start_new    <= it.start_new;
        codeword     <= it.codeword;
        code_length  <= it.code_length;
        symbol_index <= it.symbol_index;
        next_valid   = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          // random gaps so they land on every phase of the walk
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 48);
        end
      end
    end
    in_valid <= next_valid;  // single update per edge, so valid never glitches
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready runs alternating with stalls; some stalls outlast an insert
  // so the second result backs up into the sequencer and input is blocked.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int run_left   = 0;

  always @(negedge clk) begin : receiver
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (run_left > 0) begin
      out_ready <= 1'b1;
      run_left--;
    end else begin
      out_ready  <= 1'b1;
      run_left   = $urandom_range(1, 60);
      stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks output transfers, predicts on input transfers
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    tree_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("unexpected result", status, 0);
        end else begin
          want = expected_results.pop_front();
          results_seen++;
          if (status !== want.status)
            flag_mismatch("status", status, want.status);
          if (node_count !== want.node_count)
            flag_mismatch("node_count", node_count, want.node_count);
          if (tree_complete !== want.tree_complete)
            flag_mismatch("tree_complete", tree_complete, want.tree_complete);
          if (longest_length !== want.longest_length)
            flag_mismatch("longest_length", longest_length, want.longest_length);
          status_tally[want.status]++;
          if (want.tree_complete) complete_tally++;
          if (int'(want.node_count) > peak_count) peak_count = int'(want.node_count);
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(insert_code(
          insert_t'{start_new, codeword, code_length, symbol_index}));
        in_taken = 1'b1;
        inserts_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Queues an insert; code bits above the length get random junk, which the
  // block has to ignore.
  task automatic push_insert(bit fresh, logic [31:0] code, int len, logic [8:0] sym);
    insert_t     it;
    logic [31:0] junk;
    junk = $urandom;
    if (len < 32) code = (junk << len) | (code & ((32'h1 << len) - 32'h1));
    it.start_new    = fresh;
    it.codeword     = code;
    it.code_length  = LEN_W'(len);
    it.symbol_index = sym;
    pending_inserts.push_back(it);
  endtask

  initial begin : stimulus
    logic [31:0] leaf_code[$];
    int          leaf_len[$];
    logic [31:0] c;
    int          l;
    int          k;
    int          i;
    int          j;
    int          pick;
    int          depth_cap;
    bit          first;

    longest_seen = 0;
    clear_tree();

    // directed: zero length, both one-bit leaves, extremes of length and
    // symbol, saturated lengths, ending on internal nodes, leaves in the path
    push_insert(1'b0, 32'hFFFF_FFFF, 0, 9'd0);     // zero length on reset tree
    push_insert(1'b1, 32'h0, 1, 9'd0);
    push_insert(1'b0, 32'h1, 1, 9'd511);           // tree now complete
    push_insert(1'b0, 32'h0, 2, 9'd3);             // runs into leaf "0"
    push_insert(1'b0, 32'h0, 0, 9'd7);             // zero length, complete tree
    push_insert(1'b1, 32'hFFFF_FFFF, 32, 9'd5);    // longest chain, 31 new nodes
    push_insert(1'b0, 32'hFFFF_FFFF, 16, 9'd6);    // stops on an internal node
    push_insert(1'b0, 32'hFFFF_FFFF, 63, 9'd9);    // saturates, hits own leaf
    push_insert(1'b0, 32'hFFFF_FFFE, 40, 9'd10);   // saturates, sibling leaf
    push_insert(1'b0, 32'h0, 33, 9'd11);           // saturates, new deep branch
    push_insert(1'b1, 32'h2, 2, 9'd12);
    push_insert(1'b0, 32'h0, 1, 9'd13);
    push_insert(1'b0, 32'h3, 2, 9'd14);            // complete again
    push_insert(1'b0, 32'h1, 1, 9'd15);            // internal node on full tree
    push_insert(1'b0, 32'h7, 3, 9'd256);           // leaf in path at depth 2

    while (pending_inserts.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // well-formed prefix code: grow a complete code by splitting leaves,
        // send it shuffled, occasionally drop a leaf or add a conflicting code
        depth_cap = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 32)
                                                : $urandom_range(2, 12);
        leaf_code = '{32'h0, 32'h1};
        leaf_len  = '{1, 1};
        repeat ($urandom_range(0, 30)) begin
          k = $urandom_range(0, leaf_code.size() - 1);
          if (leaf_len[k] < depth_cap) begin
            c = leaf_code[k];
            l = leaf_len[k];
            leaf_code[k] = c << 1;
            leaf_len[k]  = l + 1;
            leaf_code.push_back((c << 1) | 32'h1);
            leaf_len.push_back(l + 1);
          end
        end
        for (i = leaf_code.size() - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          c = leaf_code[i]; leaf_code[i] = leaf_code[j]; leaf_code[j] = c;
          l = leaf_len[i];  leaf_len[i]  = leaf_len[j];  leaf_len[j]  = l;
        end
        first = 1'b1;
        for (i = 0; i < leaf_code.size(); i++) begin
          c = leaf_code[i];
          l = leaf_len[i];
          if (first || $urandom_range(0, 15) != 0) begin
            push_insert(first, c, l, 9'($urandom));
            first = 1'b0;
          end
          if ($urandom_range(0, 11) == 0) begin
            case ($urandom_range(0, 2))
              0: push_insert(1'b0, c, l, 9'($urandom));   // duplicate
              1: if (l > 1) begin                         // prefix of the code
                k = $urandom_range(1, l - 1);
                push_insert(1'b0, c >> k, l - k, 9'($urandom));
              end
              default: if (l < 32) begin                  // extension past a leaf
                k = $urandom_range(1, 32 - l);
                push_insert(1'b0, (c << k) | ($urandom & ((32'h1 << k) - 32'h1)),
                            l + k, 9'($urandom));
              end
            endcase
          end
        end
      end else if (pick < 55) begin
        // long random codes on a fresh tree until the node store runs out
        first = 1'b1;
        repeat ($urandom_range(22, 34)) begin
          push_insert(first, $urandom, $urandom_range(28, 32), 9'($urandom));
          first = 1'b0;
        end
      end else if (pick < 80) begin
        // short codes added to whatever tree is there
        repeat ($urandom_range(1, 12))
          push_insert(1'b0, $urandom, $urandom_range(1, 8), 9'($urandom));
      end else begin
        // noise: any length the field holds, occasional restarts
        repeat ($urandom_range(1, 6))
          push_insert($urandom_range(0, 7) == 0, $urandom, $urandom_range(0, 63),
                      9'($urandom));
      end
    end

    // the sender uses its own model instance state only through the monitor,
    // so reset the predictor tree again before the first transfer
    longest_seen = 0;
    clear_tree();

    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending_inserts.size() > 0 || in_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);  // catch any stray extra result

    $display("Covered %0d inserts: %0d ok, %0d blocked by a leaf, %0d rejected as full.",
             inserts_taken, status_tally[ST_OK], status_tally[ST_LEAF_IN_PATH],
             status_tally[ST_FULL]);
    $display("Trees reported complete %0d times; peak internal node count %0d.",
             complete_tally, peak_count);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run (~1650 inserts, each with
  // the work of a full walk, the longest sender gap and receiver stall).
  initial begin : watchdog
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
